### design/gzhc_pkg.sv
// ----------------------------------------------------------------------------
// gzhc_pkg
// shared types, status codes and header constants for the gzip header checker
// ----------------------------------------------------------------------------
package gzhc_pkg;

  localparam int DEFAULT_COUNT_WIDTH = 32;

  localparam logic [7:0] MAGIC0         = 8'h1f;
  localparam logic [7:0] MAGIC1         = 8'h8b;
  localparam logic [7:0] METHOD_DEFLATE = 8'd8;
  localparam logic [7:0] FLG_RESERVED   = 8'he0;

  localparam int FLG_FHCRC    = 1;
  localparam int FLG_FEXTRA   = 2;
  localparam int FLG_FNAME    = 3;
  localparam int FLG_FCOMMENT = 4;

  localparam int FIXED_HDR_LAST   = 9;
  localparam int MIN_STREAM_BYTES = 18;
  localparam int FOOTER_BYTES     = 8;

  localparam logic [15:0] HCRC_BYTES = 16'd2;

  localparam logic [3:0] ST_OK            = 4'd0;
  localparam logic [3:0] ST_TOO_SHORT     = 4'd1;
  localparam logic [3:0] ST_BAD_MAGIC     = 4'd2;
  localparam logic [3:0] ST_BAD_METHOD    = 4'd3;
  localparam logic [3:0] ST_RSVD_FLAGS    = 4'd4;
  localparam logic [3:0] ST_EXTRA_TRUNC   = 4'd5;
  localparam logic [3:0] ST_STRING_TRUNC  = 4'd6;
  localparam logic [3:0] ST_HCRC_TRUNC    = 4'd7;
  localparam logic [3:0] ST_NO_FOOTER     = 4'd8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] header_length;
  } out_word_t;

endpackage

### design/gzhc_in_stage.sv
// ----------------------------------------------------------------------------
// gzhc_in_stage
// input register: holds one word until the parser consumes it
// ----------------------------------------------------------------------------
module gzhc_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  gzhc_pkg::in_word_t in_word,
  output logic               item_valid,
  output gzhc_pkg::in_word_t item_word,
  input  logic               item_take
);
  import gzhc_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_word_t word_r;
  logic     accept;

  assign in_stall   = valid_r && !item_take;
  assign accept     = in_valid && !in_stall;
  assign item_valid = valid_r;
  assign item_word  = word_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (item_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word_r <= in_word;
    end
  end

endmodule

### design/gzhc_parser.sv
// ----------------------------------------------------------------------------
// gzhc_parser
// per-byte header phase tracking, byte count and final status decision
// ----------------------------------------------------------------------------
module gzhc_parser #(
  parameter int COUNT_WIDTH = gzhc_pkg::DEFAULT_COUNT_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_fire,
  input  gzhc_pkg::in_word_t  item_word,
  output gzhc_pkg::out_word_t res_word
);
  import gzhc_pkg::*;

  typedef enum logic [8:0] {
    PH_HDR     = 9'b000000001,
    PH_XLEN0   = 9'b000000010,
    PH_XLEN1   = 9'b000000100,
    PH_EXTRA   = 9'b000001000,
    PH_NAME    = 9'b000010000,
    PH_COMMENT = 9'b000100000,
    PH_HCRC    = 9'b001000000,
    PH_DONE    = 9'b010000000,
    PH_ERR     = 9'b100000000
  } phase_t;

  localparam logic [2:0] FROM_XLEN    = 3'd0;
  localparam logic [2:0] FROM_NAME    = 3'd1;
  localparam logic [2:0] FROM_COMMENT = 3'd2;
  localparam logic [2:0] FROM_HCRC    = 3'd3;
  localparam logic [2:0] FROM_DONE    = 3'd4;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  function automatic phase_t enter_from(logic [2:0] from, logic [7:0] flg);
    phase_t ph;
    ph = PH_DONE;
    if (from <= FROM_XLEN && flg[FLG_FEXTRA]) begin
      ph = PH_XLEN0;
    end else if (from <= FROM_NAME && flg[FLG_FNAME]) begin
      ph = PH_NAME;
    end else if (from <= FROM_COMMENT && flg[FLG_FCOMMENT]) begin
      ph = PH_COMMENT;
    end else if (from <= FROM_HCRC && flg[FLG_FHCRC]) begin
      ph = PH_HCRC;
    end
    return ph;
  endfunction

  phase_t                 phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [7:0]             flags_r, flags_nxt;
  logic [7:0]             xlo_r, xlo_nxt;
  logic [15:0]            skip_r, skip_nxt;
  logic [COUNT_WIDTH-1:0] hend_r, hend_nxt;
  logic [3:0]             err_r, err_nxt;

  logic [7:0]             b;
  logic                   enter_go;
  logic [2:0]             enter_sel;
  logic [3:0]             status;
  logic [31:0]            hend_low;

  assign b = item_word.data_byte;

  always_comb begin
    cnt_nxt   = (cnt_r != CNT_MAX) ? cnt_r + 1'b1 : cnt_r;
    phase_nxt = phase_r;
    flags_nxt = flags_r;
    xlo_nxt   = xlo_r;
    skip_nxt  = skip_r;
    hend_nxt  = hend_r;
    err_nxt   = err_r;
    enter_go  = 1'b0;
    enter_sel = FROM_DONE;

    case (phase_r)
      PH_HDR: begin
        if (cnt_r == '0 && b != MAGIC0) begin
          phase_nxt = PH_ERR;
          err_nxt   = ST_BAD_MAGIC;
        end else if (cnt_r == COUNT_WIDTH'(1) && b != MAGIC1) begin
          phase_nxt = PH_ERR;
          err_nxt   = ST_BAD_MAGIC;
        end else if (cnt_r == COUNT_WIDTH'(2) && b != METHOD_DEFLATE) begin
          phase_nxt = PH_ERR;
          err_nxt   = ST_BAD_METHOD;
        end else if (cnt_r == COUNT_WIDTH'(3)) begin
          flags_nxt = b;
          if ((b & FLG_RESERVED) != 8'd0) begin
            phase_nxt = PH_ERR;
            err_nxt   = ST_RSVD_FLAGS;
          end
        end else if (cnt_r >= COUNT_WIDTH'(FIXED_HDR_LAST)) begin
          enter_go  = 1'b1;
          enter_sel = FROM_XLEN;
        end
      end
      PH_XLEN0: begin
        xlo_nxt   = b;
        phase_nxt = PH_XLEN1;
      end
      PH_XLEN1: begin
        skip_nxt = {b, xlo_r};
        if ({b, xlo_r} == 16'd0) begin
          enter_go  = 1'b1;
          enter_sel = FROM_NAME;
        end else begin
          phase_nxt = PH_EXTRA;
        end
      end
      PH_EXTRA: begin
        skip_nxt = skip_r - 16'd1;
        if (skip_r == 16'd1) begin
          enter_go  = 1'b1;
          enter_sel = FROM_NAME;
        end
      end
      PH_NAME: begin
        if (b == 8'd0) begin
          enter_go  = 1'b1;
          enter_sel = FROM_COMMENT;
        end
      end
      PH_COMMENT: begin
        if (b == 8'd0) begin
          enter_go  = 1'b1;
          enter_sel = FROM_HCRC;
        end
      end
      PH_HCRC: begin
        skip_nxt = skip_r - 16'd1;
        if (skip_r == 16'd1) begin
          enter_go  = 1'b1;
          enter_sel = FROM_DONE;
        end
      end
      default: begin
      end
    endcase

    if (enter_go) begin
      phase_nxt = enter_from(enter_sel, flags_r);
      if (phase_nxt == PH_HCRC) begin
        skip_nxt = HCRC_BYTES;
      end
      if (phase_nxt == PH_DONE) begin
        hend_nxt = cnt_nxt;
      end
    end
  end

  // final status in priority order
  always_comb begin
    if (cnt_nxt < COUNT_WIDTH'(MIN_STREAM_BYTES)) begin
      status = ST_TOO_SHORT;
    end else if (err_nxt != ST_OK) begin
      status = err_nxt;
    end else if (phase_nxt inside {PH_XLEN0, PH_XLEN1, PH_EXTRA}) begin
      status = ST_EXTRA_TRUNC;
    end else if (phase_nxt inside {PH_NAME, PH_COMMENT}) begin
      status = ST_STRING_TRUNC;
    end else if (phase_nxt == PH_HCRC) begin
      status = ST_HCRC_TRUNC;
    end else if (phase_nxt != PH_DONE ||
                 (cnt_nxt - hend_nxt) < COUNT_WIDTH'(FOOTER_BYTES)) begin
      status = ST_NO_FOOTER;
    end else begin
      status = ST_OK;
    end
  end

  generate
    if (COUNT_WIDTH >= 32) begin : g_wide
      assign hend_low = hend_nxt[31:0];
    end else begin : g_narrow
      assign hend_low = {{(32-COUNT_WIDTH){1'b0}}, hend_nxt};
    end
  endgenerate

  assign res_word.status        = status;
  assign res_word.header_length = (status == ST_OK) ? hend_low : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR;
      cnt_r   <= '0;
      flags_r <= 8'd0;
      xlo_r   <= 8'd0;
      skip_r  <= 16'd0;
      hend_r  <= '0;
      err_r   <= ST_OK;
    end else if (item_fire) begin
      if (item_word.last) begin
        phase_r <= PH_HDR;
        cnt_r   <= '0;
        flags_r <= 8'd0;
        xlo_r   <= 8'd0;
        skip_r  <= 16'd0;
        hend_r  <= '0;
        err_r   <= ST_OK;
      end else begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        flags_r <= flags_nxt;
        xlo_r   <= xlo_nxt;
        skip_r  <= skip_nxt;
        hend_r  <= hend_nxt;
        err_r   <= err_nxt;
      end
    end
  end

endmodule

### design/gzhc_out_stage.sv
// ----------------------------------------------------------------------------
// gzhc_out_stage
// result register: holds one status word until the receiver takes it
// ----------------------------------------------------------------------------
module gzhc_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_load,
  input  gzhc_pkg::out_word_t res_word,
  output logic                res_free,
  output logic                out_valid,
  input  logic                out_stall,
  output gzhc_pkg::out_word_t out_word
);
  import gzhc_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  out_word_t word_r;

  assign res_free  = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_word  = word_r;

  always_comb begin
    valid_nxt = valid_r;
    if (res_load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      word_r <= res_word;
    end
  end

endmodule

### design/gzip_header_checker.sv
// ----------------------------------------------------------------------------
// gzip_header_checker
// checks a gzip member header byte by byte and reports status on the last byte
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle with no gaps needed between streams. Each
// byte is registered, the header phase is updated in a single pass, and the
// status word for a byte marked last is formed as that byte leaves the input
// register and is held in a result register so input keeps flowing while
// the receiver stalls. Only a last byte waiting on a full, stalled result
// register holds up the input. Throughput is one byte per clock outside
// that stall. No clearing pass after reset.
module gzip_header_checker #(
  parameter int COUNT_WIDTH = gzhc_pkg::DEFAULT_COUNT_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gzhc_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output gzhc_pkg::out_word_t out_word
);
  import gzhc_pkg::*;

  logic      item_valid;
  in_word_t  item_word;
  logic      item_fire;
  logic      res_free;
  out_word_t res_word;

  assign item_fire = item_valid && (!item_word.last || res_free);

  gzhc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .item_valid (item_valid),
    .item_word  (item_word),
    .item_take  (item_fire)
  );

  gzhc_parser #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_fire (item_fire),
    .item_word (item_word),
    .res_word  (res_word)
  );

  gzhc_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (item_fire && item_word.last),
    .res_word  (res_word),
    .res_free  (res_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

### design/gzhc_checker.sv
// ----------------------------------------------------------------------------
// gzhc_checker
// port-level checks for the gzip header checker, bound to the top level
// ----------------------------------------------------------------------------
module gzhc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input gzhc_pkg::in_word_t  in_word,
  input logic                out_valid,
  input logic                out_stall,
  input gzhc_pkg::out_word_t out_word
);
  import gzhc_pkg::*;

  // no result word right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word shown right after reset");

  // a stalled input word holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_word))
    else $error("stalled input word changed");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  // offset only reported with good status
  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status != ST_OK |-> out_word.header_length == 32'd0)
    else $error("header length nonzero on error status");

  // status stays within the defined codes
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.status <= ST_NO_FOOTER)
    else $error("undefined status code");

endmodule

bind gzip_header_checker gzhc_checker u_gzhc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// gzip member header checker: streams in, one status word per stream out
// ----------------------------------------------------------------------------
// Directed members cover valid headers, each header error, each truncation
// point, a missing footer and an extra field longer than 255 bytes. Random
// members follow: mostly well-formed headers with random optional sections,
// plus cut-off streams, corrupted fixed headers and plain noise, under several
// mixes of sender gaps and receiver stalls. One pass holds the receiver off
// long enough to back the block up into its input. Every result word is
// checked against an in-order prediction of the header state machine.
// ----------------------------------------------------------------------------
module testbench;
  import gzhc_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 10;

  typedef enum logic [3:0] {
    P_FIXED, P_XLEN_LO, P_XLEN_HI, P_EXTRA, P_NAME, P_COMMENT, P_HCRC, P_BODY, P_ERROR
  } hdr_phase_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  gzip_header_checker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // header tracking state
  hdr_phase_t  ph;
  logic [31:0] nbytes;
  logic [31:0] hdr_end;
  logic [7:0]  flg;
  logic [7:0]  xlen_lo;
  logic [15:0] skip_left;
  logic [3:0]  err_code;

  out_word_t   status_q[$];
  out_word_t   predicted_word;
  out_word_t   expected_word;
  logic [7:0]  stream_q[$];
  int          mismatches = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_left = 0;
  logic        hold_req = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  function automatic void add_byte(input logic [7:0] v);
    stream_q = {stream_q, v};
  endfunction

  function automatic void add_status(input out_word_t w);
    status_q = {status_q, w};
  endfunction

  function automatic void clear_header_state();
    ph        = P_FIXED;
    nbytes    = '0;
    hdr_end   = '0;
    flg       = '0;
    xlen_lo   = '0;
    skip_left = '0;
    err_code  = ST_OK;
  endfunction

  function automatic void latch_error(input logic [3:0] code);
    err_code = code;
    ph       = P_ERROR;
  endfunction

  // first enabled optional section at or after the given one
  function automatic void open_section(input hdr_phase_t from);
    if (from <= P_XLEN_LO && flg[FLG_FEXTRA]) begin
      ph = P_XLEN_LO;
    end else if (from <= P_NAME && flg[FLG_FNAME]) begin
      ph = P_NAME;
    end else if (from <= P_COMMENT && flg[FLG_FCOMMENT]) begin
      ph = P_COMMENT;
    end else if (from <= P_HCRC && flg[FLG_FHCRC]) begin
      ph        = P_HCRC;
      skip_left = HCRC_BYTES;
    end else begin
      ph      = P_BODY;
      hdr_end = nbytes;
    end
  endfunction

  function automatic bit predict_status(input in_word_t w, output out_word_t r);
    logic [31:0] pos;
    logic [7:0]  b;
    b   = w.data_byte;
    pos = nbytes;
    r   = '0;
    if (nbytes != '1) nbytes = nbytes + 1;
    case (ph)
      P_FIXED: begin
        if (pos == 0 && b != MAGIC0) begin
          latch_error(ST_BAD_MAGIC);
        end else if (pos == 1 && b != MAGIC1) begin
          latch_error(ST_BAD_MAGIC);
        end else if (pos == 2 && b != METHOD_DEFLATE) begin
          latch_error(ST_BAD_METHOD);
        end else if (pos == 3) begin
          flg = b;
          if ((b & FLG_RESERVED) != 0) latch_error(ST_RSVD_FLAGS);
        end else if (pos >= FIXED_HDR_LAST) begin
          open_section(P_XLEN_LO);
        end
      end
      P_XLEN_LO: begin
        xlen_lo = b;
        ph      = P_XLEN_HI;
      end
      P_XLEN_HI: begin
        skip_left = {b, xlen_lo};
        if (skip_left == 0) open_section(P_NAME);
        else ph = P_EXTRA;
      end
      P_EXTRA: begin
        skip_left = skip_left - 1;
        if (skip_left == 0) open_section(P_NAME);
      end
      P_NAME: begin
        if (b == 0) open_section(P_COMMENT);
      end
      P_COMMENT: begin
        if (b == 0) open_section(P_HCRC);
      end
      P_HCRC: begin
        skip_left = skip_left - 1;
        if (skip_left == 0) open_section(P_BODY);
      end
      default: ;
    endcase
    if (!w.last) return 1'b0;
    if (nbytes < MIN_STREAM_BYTES) begin
      r.status = ST_TOO_SHORT;
    end else if (err_code != ST_OK) begin
      r.status = err_code;
    end else if (ph == P_XLEN_LO || ph == P_XLEN_HI || ph == P_EXTRA) begin
      r.status = ST_EXTRA_TRUNC;
    end else if (ph == P_NAME || ph == P_COMMENT) begin
      r.status = ST_STRING_TRUNC;
    end else if (ph == P_HCRC) begin
      r.status = ST_HCRC_TRUNC;
    end else if (ph != P_BODY || nbytes - hdr_end < FOOTER_BYTES) begin
      r.status = ST_NO_FOOTER;
    end else begin
      r.status        = ST_OK;
      r.header_length = hdr_end;
    end
    clear_header_state();
    return 1'b1;
  endfunction

  // predict on each accepted word, check each accepted result
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall && predict_status(in_word, predicted_word))
        add_status(predicted_word);
      if (out_valid && !out_stall) begin
        if (status_q.size() == 0) begin
          $display("%0t: unexpected result status %0d header_length %0d",
                   $time, out_word.status, out_word.header_length);
          mismatches++;
        end else begin
          expected_word = status_q.pop_front();
          if (out_word.status !== expected_word.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, expected_word.status, out_word.status);
            mismatches++;
          end
          if (out_word.header_length !== expected_word.header_length) begin
            $display("%0t: header_length expected %0d actual %0d",
                     $time, expected_word.header_length, out_word.header_length);
            mismatches++;
          end
        end
      end
    end
  end

  // receiver stalls, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_word(input logic [7:0] data, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= {data, is_last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_stream();
    for (int i = 0; i < stream_q.size(); i++)
      send_word(stream_q[i], i == stream_q.size() - 1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    @(posedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    @(negedge clk);
  endtask

  task automatic build_member(input logic [7:0] flags, input logic [15:0] xlen,
                              input int name_len, input int comment_len,
                              input int body_len);
    stream_q.delete();
    add_byte(MAGIC0);
    add_byte(MAGIC1);
    add_byte(METHOD_DEFLATE);
    add_byte(flags);
    repeat (6) add_byte(8'($urandom));
    if (flags[FLG_FEXTRA]) begin
      add_byte(xlen[7:0]);
      add_byte(xlen[15:8]);
      repeat (xlen) add_byte(8'($urandom));
    end
    if (flags[FLG_FNAME]) begin
      repeat (name_len) add_byte(8'($urandom_range(1, 255)));
      add_byte(8'h00);
    end
    if (flags[FLG_FCOMMENT]) begin
      repeat (comment_len) add_byte(8'($urandom_range(1, 255)));
      add_byte(8'h00);
    end
    if (flags[FLG_FHCRC]) repeat (2) add_byte(8'($urandom));
    repeat (body_len) add_byte(8'($urandom));
  endtask

  task automatic cut_stream(input int keep);
    while (stream_q.size() > keep) stream_q.delete(stream_q.size() - 1);
  endtask

  task automatic random_stream();
    int         kind;
    int         pos;
    logic [7:0] flags;
    kind  = $urandom_range(99);
    flags = 8'($urandom_range(0, 31));
    if (kind < 60) begin
      build_member(flags, 16'($urandom_range(0, 12)), $urandom_range(0, 6),
                   $urandom_range(0, 6), $urandom_range(0, 16));
    end else if (kind < 75) begin
      build_member(flags, 16'($urandom_range(0, 12)), $urandom_range(0, 6),
                   $urandom_range(0, 6), $urandom_range(0, 12));
      cut_stream($urandom_range(1, stream_q.size()));
    end else if (kind < 83) begin
      // random extra length, so the cut usually falls inside the extra field
      build_member(flags | 8'h04, 16'($urandom), 0, 0, 0);
      cut_stream($urandom_range(MIN_STREAM_BYTES, 50));
    end else if (kind < 91) begin
      build_member(flags, 16'($urandom_range(0, 8)), $urandom_range(0, 4),
                   $urandom_range(0, 4), $urandom_range(0, 12));
      pos = $urandom_range(0, 3);
      if (pos == 3) stream_q[3] = flags | (8'($urandom_range(1, 7)) << 5);
      else stream_q[pos] = stream_q[pos] ^ 8'($urandom_range(1, 255));
    end else begin
      stream_q.delete();
      repeat ($urandom_range(1, 40)) add_byte(8'($urandom));
    end
  endtask

  task automatic test_valid_members();
    build_member(8'h00, 16'd0, 0, 0, FOOTER_BYTES);
    send_stream();
    build_member(8'h1f, 16'd3, 2, 2, FOOTER_BYTES);
    send_stream();
    build_member(8'h1e, 16'd0, 0, 0, FOOTER_BYTES + 3);
    for (int i = 4; i < 10; i++) stream_q[i] = 8'hff;
    send_stream();
    build_member(8'h00, 16'd0, 0, 0, FOOTER_BYTES - 1);
    send_stream();
    drain();
  endtask

  task automatic test_header_errors();
    build_member(8'h00, 16'd0, 0, 0, FOOTER_BYTES);
    stream_q[0] = 8'hff;
    send_stream();
    build_member(8'h00, 16'd0, 0, 0, FOOTER_BYTES);
    stream_q[1] = 8'h00;
    send_stream();
    build_member(8'h08, 16'd0, 4, 0, FOOTER_BYTES);
    stream_q[2] = 8'h07;
    send_stream();
    build_member(8'h00, 16'd0, 0, 0, FOOTER_BYTES);
    stream_q[3] = FLG_RESERVED;
    send_stream();
    // header error in a stream too short to count
    build_member(8'h00, 16'd0, 0, 0, FOOTER_BYTES - 1);
    stream_q[0] = 8'h00;
    send_stream();
    stream_q.delete();
    add_byte(8'h00);
    send_stream();
    stream_q[0] = 8'hff;
    send_stream();
    drain();
  endtask

  task automatic test_truncation();
    build_member(8'h04, 16'd20, 0, 0, 0);
    cut_stream(MIN_STREAM_BYTES);
    send_stream();
    build_member(8'h08, 16'd0, 20, 0, 0);
    cut_stream(20);
    send_stream();
    build_member(8'h10, 16'd0, 0, 20, 0);
    cut_stream(20);
    send_stream();
    build_member(8'h0a, 16'd0, 10, 0, 0);
    cut_stream(stream_q.size() - 1);
    send_stream();
    // stream ends right where deflate data would start
    build_member(8'h08, 16'd0, 10, 0, 0);
    send_stream();
    drain();
  endtask

  task automatic test_long_extra();
    build_member(8'h04, 16'h0100, 0, 0, FOOTER_BYTES);
    send_stream();
    build_member(8'h06, 16'h0001, 0, 0, FOOTER_BYTES);
    send_stream();
    drain();
  endtask

  task automatic test_random_streams(input int send_pct, input int recv_pct,
                                     input int byte_target);
    int sent;
    sent = 0;
    set_idling(send_pct, recv_pct);
    while (sent < byte_target) begin
      random_stream();
      sent += stream_q.size();
      send_stream();
    end
    drain();
  endtask

  task automatic test_backpressure();
    set_idling(0, 0);
    @(posedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    repeat (12) begin
      if ($urandom_range(1)) begin
        stream_q.delete();
        add_byte(8'($urandom));
      end else begin
        random_stream();
      end
      send_stream();
    end
    drain();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    out_stall = 1'b0;
    clear_header_state();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_valid_members();
    test_header_errors();
    test_truncation();
    test_long_extra();
    test_random_streams(0, 0, 120);
    test_random_streams(52, 0, 120);
    test_random_streams(0, 52, 120);
    test_random_streams(12, 12, 120);
    test_backpressure();

    if (mismatches == 0 && status_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
